/* design/lpht_pkg.sv */
// Shared types and constants for the linear-probe hash table.
// Used by the hash pipeline and the table core; no dependencies.
package lpht_pkg;

   localparam int SLOTS   = 4096;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int KEY_W   = 64;
   localparam int VAL_W   = 64;
   localparam int STAT_W  = 3;
   localparam int LIMIT_W = 12;
   localparam int COUNT_W = LIMIT_W + 1;

   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SLOTS - 1);
   localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = LIMIT_W'(2867);

   // splitmix64 finalizer
   localparam logic [63:0] MIX_C1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2  = 64'h94d049bb133111eb;
   localparam int          MIX_SH1 = 30;
   localparam int          MIX_SH2 = 27;
   localparam int          MIX_SH3 = 31;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_FIND   = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_UPDATED   = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_FOUND     = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd4;

   typedef struct packed {
      logic                    mode;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  found_value;
   } rsp_type;

endpackage

/* design/lpht_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lpht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* design/lpht_hash.sv */
// Four-stage splitmix64 finalizer giving the home slot of a key.
// Depends on lpht_pkg; each 64-bit product is built from 32x32 partial products.
module lpht_hash
   import lpht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [63:0]      in_key,
   output logic             out_valid,
   output logic [IDX_W-1:0] out_idx
);

   logic [3:0]  valid_ff;
   logic [63:0] x0;
   logic [63:0] a_ll_full, a_hl_full, a_lh_full;
   logic [63:0] a_ll_ff;
   logic [31:0] a_hl_ff, a_lh_ff;
   logic [63:0] m1, y;
   logic [63:0] y_ff;
   logic [63:0] c_ll_full, c_hl_full, c_lh_full;
   logic [63:0] c_ll_ff;
   logic [31:0] c_hl_ff, c_lh_ff;
   logic [31:0] a_cross, c_cross;
   logic [63:0] m2, h;
   logic [IDX_W-1:0] idx_ff;

   // first multiply: low 64 bits of x0 * C1
   assign x0        = in_key ^ (in_key >> MIX_SH1);
   assign a_ll_full = x0[31:0]  * MIX_C1[31:0];
   assign a_hl_full = x0[63:32] * MIX_C1[31:0];
   assign a_lh_full = x0[31:0]  * MIX_C1[63:32];

   assign a_cross = a_hl_ff + a_lh_ff;
   assign m1      = a_ll_ff + {a_cross, 32'b0};
   assign y       = m1 ^ (m1 >> MIX_SH2);

   // second multiply: low 64 bits of y * C2
   assign c_ll_full = y_ff[31:0]  * MIX_C2[31:0];
   assign c_hl_full = y_ff[63:32] * MIX_C2[31:0];
   assign c_lh_full = y_ff[31:0]  * MIX_C2[63:32];

   assign c_cross = c_hl_ff + c_lh_ff;
   assign m2      = c_ll_ff + {c_cross, 32'b0};
   assign h       = m2 ^ (m2 >> MIX_SH3);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      a_ll_ff <= a_ll_full;
      a_hl_ff <= a_hl_full[31:0];
      a_lh_ff <= a_lh_full[31:0];
      y_ff    <= y;
      c_ll_ff <= c_ll_full;
      c_hl_ff <= c_hl_full[31:0];
      c_lh_ff <= c_lh_full[31:0];
      idx_ff  <= h[IDX_W-1:0];
   end

   assign out_valid = valid_ff[3];
   assign out_idx   = idx_ff;

endmodule

/* design/linear_probe_hash_table_core.sv */
// Linear-probe hash table core: a request is accepted when start is high and busy low.
// The key is hashed, then the slots are read one at a time from its home slot; busy falls
// together with the result strobe, so the next item can be accepted while the strobe is
// high; items never overlap, and each slot memory has a single read port.
// After reset a clearing pass marks every slot empty; busy is high meanwhile.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
module linear_probe_hash_table_core
   import lpht_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   probes_ff, probes_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   req_type            req_ff, req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               hash_valid;
   logic [IDX_W-1:0]   hash_idx;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               kw_en;
   logic [IDX_W-1:0]   kw_addr;
   logic [KEY_W:0]     kw_data;
   logic [KEY_W:0]     k_rd;
   logic               vw_en;
   logic [VAL_W-1:0]   v_rd;

   logic               slot_used;
   logic               slot_hit;
   logic               is_find;

   lpht_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  ((state_ff == S_IDLE) && start),
      .in_key    (req_data.key),
      .out_valid (hash_valid),
      .out_idx   (hash_idx)
   );

   // used flag in the top bit, key below
   lpht_ram #(.WIDTH(KEY_W + 1), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (kw_en),
      .wr_addr (kw_addr),
      .wr_data (kw_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (k_rd)
   );

   lpht_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (vw_en),
      .wr_addr (pos_ff),
      .wr_data (req_ff.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (v_rd)
   );

   assign slot_used = k_rd[KEY_W];
   assign slot_hit  = slot_used && (k_rd[KEY_W-1:0] == $unsigned(req_ff.key));
   assign is_find   = (req_ff.mode == MODE_FIND);

   // One item is in flight at a time and writes land in the last probe cycle,
   // so reads of the next item never overlap a pending write.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      probes_in    = probes_ff;
      count_in     = count_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_ff;
      kw_en        = 1'b0;
      kw_addr      = pos_ff;
      kw_data      = {1'b1, $unsigned(req_ff.key)};
      vw_en        = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            kw_en   = 1'b1;
            kw_addr = clr_ff;
            kw_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_MAX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_valid) begin
               pos_in    = hash_idx;
               probes_in = '0;
               rd_en     = 1'b1;
               rd_addr   = hash_idx;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            rsp_in.found_value = '0;
            priority if (!slot_used) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (is_find) begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end else if (count_ff < {1'b0, limit_ff}) begin
                  kw_en         = 1'b1;
                  vw_en         = 1'b1;
                  count_in      = count_ff + 1'b1;
                  rsp_in.status = STATUS_INSERTED;
               end else begin
                  rsp_in.status = STATUS_FULL;
               end
            end else if (slot_hit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (is_find) begin
                  rsp_in.status      = STATUS_FOUND;
                  rsp_in.found_value = v_rd;
               end else begin
                  vw_en         = 1'b1;
                  rsp_in.status = STATUS_UPDATED;
               end
            end else if (probes_ff == IDX_MAX) begin
               // every slot visited, no key and no hole
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
               rsp_in.status = is_find ? STATUS_NOT_FOUND : STATUS_FULL;
            end else begin
               // advance to the next slot, wrapping at the top
               pos_in    = pos_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               rd_en     = 1'b1;
               rd_addr   = pos_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         limit_ff     <= FILL_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff    <= pos_in;
      probes_ff <= probes_in;
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for linear_probe_hash_table_core: directed and random inserts and finds,
// each result checked against a behavioral copy of the table. Depends on lpht_pkg.
module tb_top
   import lpht_pkg::*;
();

   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 8;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               start       = 1'b0;
   logic               busy;
   req_type            req_data    = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   // shadow table
   bit                 tbl_used [SLOTS];
   logic [KEY_W-1:0]   tbl_key  [SLOTS];
   logic [VAL_W-1:0]   tbl_val  [SLOTS];
   logic [COUNT_W-1:0] entries      = '0;
   logic [LIMIT_W-1:0] limit_shadow = FILL_LIMIT_RESET;

   req_type            pending_reqs[$];
   rsp_type            awaited_results[$];
   logic [KEY_W-1:0]   known_keys[$];
   int                 idle_pct     = 0;
   int                 err_count    = 0;
   bit                 item_taken   = 1'b0;
   int unsigned        stall_cycles = 0;

   linear_probe_hash_table_core u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] mix_key(input logic [63:0] k);
      logic [63:0] x;
      x = k;
      x = x ^ (x >> MIX_SH1);
      x = x * MIX_C1;
      x = x ^ (x >> MIX_SH2);
      x = x * MIX_C2;
      x = x ^ (x >> MIX_SH3);
      return x;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // draw keys until one is homed in one of the four slots from lo upward
   function automatic logic [63:0] key_homed_near(input logic [IDX_W-1:0] lo);
      logic [63:0]      k;
      logic [63:0]      h;
      logic [IDX_W-1:0] gap;
      do begin
         k   = rand_word();
         h   = mix_key(k);
         gap = h[IDX_W-1:0] - lo;
      end while (gap > 3);
      return k;
   endfunction

   task automatic table_apply(input req_type r);
      logic [63:0]      h;
      logic [IDX_W-1:0] pos;
      bit               hit;
      bit               empty;
      rsp_type          want;
      h     = mix_key(r.key);
      pos   = h[IDX_W-1:0];
      hit   = 1'b0;
      empty = 1'b0;
      want  = '0;
      // index wraps by its width, so the last slot steps to slot 0
      for (int n = 0; n < SLOTS && !hit && !empty; n++) begin
         if (!tbl_used[pos])
            empty = 1'b1;
         else if (tbl_key[pos] == r.key)
            hit = 1'b1;
         else
            pos = pos + 1'b1;
      end
      if (r.mode == MODE_FIND) begin
         want.status = hit ? STATUS_FOUND : STATUS_NOT_FOUND;
         if (hit)
            want.found_value = tbl_val[pos];
      end else if (hit) begin
         tbl_val[pos] = r.value;
         want.status  = STATUS_UPDATED;
      end else if (empty && entries < limit_shadow) begin
         tbl_used[pos] = 1'b1;
         tbl_key[pos]  = r.key;
         tbl_val[pos]  = r.value;
         entries       = entries + 1'b1;
         want.status   = STATUS_INSERTED;
      end else begin
         want.status = STATUS_FULL;
      end
      awaited_results.push_back(want);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp);
      $display("mismatch %0s: got %h, want %h at %0t", what, got, exp, $realtime);
      err_count++;
   endtask

   // driver: predict at the accepting edge, present the next item at the falling edge
   always @(posedge clock) begin
      item_taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         table_apply(req_data);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= pending_reqs.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.found_value, '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.found_value !== want.found_value)
               report_mismatch("found_value", rsp_data.found_value, want.found_value);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("[linear_probe_hash_table_core] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_req(input logic mode, input logic [63:0] k, input logic [63:0] v);
      req_type r;
      r.mode  = mode;
      r.key   = k;
      r.value = v;
      pending_reqs.push_back(r);
   endtask

   task automatic push_random(input int n);
      int          sel;
      logic [63:0] k;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 35 || known_keys.size() == 0) begin
            // new key; some land in crowded runs, including the wrap at the top
            if ($urandom_range(9) == 0)
               k = key_homed_near($urandom_range(1) ? IDX_MAX - IDX_W'(3)
                                                    : IDX_W'($urandom));
            else
               k = rand_word();
            known_keys.push_back(k);
            push_req(MODE_INSERT, k, rand_word());
         end else if (sel < 60) begin
            k = known_keys[$urandom_range(known_keys.size() - 1)];
            push_req(MODE_INSERT, k, rand_word());
         end else if (sel < 85) begin
            k = known_keys[$urandom_range(known_keys.size() - 1)];
            push_req(MODE_FIND, k, rand_word());
         end else begin
            k = $urandom_range(1) ? rand_word() : key_homed_near(IDX_MAX - IDX_W'(3));
            push_req(MODE_FIND, k, rand_word());
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || start || awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      wait_idle();
      @(negedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= v;
      limit_shadow = v;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n, input int idle);
      write_limit(lim);
      idle_pct = idle;
      push_random(n);
   endtask

   initial begin
      logic [63:0] ckeys [7];
      logic [63:0] kmin;
      logic [63:0] kmax;
      logic [63:0] ones;
      kmin = 64'h8000_0000_0000_0000;
      kmax = 64'h7fff_ffff_ffff_ffff;
      ones = '1;
      for (int i = 0; i < 7; i++)
         ckeys[i] = key_homed_near(IDX_MAX - IDX_W'(3));

      // directed: empty find, key extremes, update, crowded run that wraps
      push_req(MODE_FIND,   64'd0, ones);
      push_req(MODE_INSERT, 64'd0, 64'd0);
      push_req(MODE_FIND,   64'd0, 64'd0);
      push_req(MODE_INSERT, kmin, ones);
      push_req(MODE_INSERT, kmax, 64'h5555_5555_5555_5555);
      push_req(MODE_INSERT, ones, 64'haaaa_aaaa_aaaa_aaaa);
      push_req(MODE_FIND,   kmin, 64'd0);
      push_req(MODE_FIND,   kmax, 64'd0);
      push_req(MODE_FIND,   ones, 64'd0);
      push_req(MODE_INSERT, 64'd0, ones);
      push_req(MODE_FIND,   64'd0, 64'd0);
      for (int i = 0; i < 6; i++) begin
         push_req(MODE_INSERT, ckeys[i], rand_word());
         known_keys.push_back(ckeys[i]);
      end
      push_req(MODE_FIND,   ckeys[0], 64'd0);
      push_req(MODE_FIND,   ckeys[3], 64'd0);
      push_req(MODE_FIND,   ckeys[5], 64'd0);
      push_req(MODE_FIND,   ckeys[6], 64'd0);
      push_req(MODE_INSERT, ckeys[5], ones);
      known_keys.push_back(64'd0);
      known_keys.push_back(kmin);
      known_keys.push_back(kmax);

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // limit zero and one: new keys refused, updates still land
      run_phase('0, 150, 67);
      run_phase(LIMIT_W'(1), 150, 9);
      run_phase(IDX_MAX, 600, 0);
      // limit just above the current count, so the table fills mid-phase
      wait_idle();
      run_phase(LIMIT_W'(entries + 25), 400, 67);
      run_phase(FILL_LIMIT_RESET, 400, 9);

      wait_idle();
      if (err_count == 0 && awaited_results.size() == 0)
         $display("[linear_probe_hash_table_core] OK");
      else
         $display("[linear_probe_hash_table_core] ERROR");
      $finish;
   end

endmodule

/* sim.f */
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_hash.sv
design/linear_probe_hash_table_core.sv
tb/tb_top.sv
